/* hdl/bbc_pkg.sv */
// Shared types, constants and the character classifier for the bracket checker.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 1024;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;  // '('
    localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;  // ')'
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;  // '['
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ']'

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } op_t;

    typedef enum logic {
        KIND_ROUND  = 1'b0,
        KIND_SQUARE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_YES      = 2'd0,
        VERDICT_NO       = 2'd1,
        VERDICT_OVERFLOW = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        CMD_OPEN_ROUND   = 3'd0,
        CMD_OPEN_SQUARE  = 3'd1,
        CMD_CLOSE_ROUND  = 3'd2,
        CMD_CLOSE_SQUARE = 3'd3,
        CMD_CLOSE_OTHER  = 3'd4,
        CMD_EOL          = 3'd5
    } cmd_t;

    // Handshake bundle for the command stream between front, queue and back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_stream_t;

    function automatic cmd_t classify(input logic op, input logic [7:0] ch);
        cmd_t c;
        if (op == OP_EOL)                  c = CMD_EOL;
        else if (ch == CHAR_OPEN_ROUND)    c = CMD_OPEN_ROUND;
        else if (ch == CHAR_OPEN_SQUARE)   c = CMD_OPEN_SQUARE;
        else if (ch == CHAR_CLOSE_ROUND)   c = CMD_CLOSE_ROUND;
        else if (ch == CHAR_CLOSE_SQUARE)  c = CMD_CLOSE_SQUARE;
        else                               c = CMD_CLOSE_OTHER;
        return c;
    endfunction

endpackage

/* hdl/bbc_front.sv */
// Front stage: accept input transactions and register their classified command.
`timescale 1ns / 1ps

module bbc_front import bbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_ch,
    output cmd_stream_t cmd_out,
    input  logic        cmd_ready
);

    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg, cmd_next;

    // Advance when the stage is empty or its command moves on.
    assign s_ready = !cmd_valid_reg || cmd_ready;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (s_ready) begin
            cmd_valid_next = s_valid;
            if (s_valid) begin
                cmd_next = classify(s_op, s_ch);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_out.valid = cmd_valid_reg;
    assign cmd_out.cmd   = cmd_reg;

endmodule

/* hdl/bbc_queue.sv */
// Short command queue that decouples the front stage from the stack engine.
`timescale 1ns / 1ps

module bbc_queue import bbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_stream_t in_cmd,
    output logic        in_ready,
    output cmd_stream_t out_cmd,
    input  logic        out_ready
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           slot_mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign in_ready      = count_reg != CW'(QUEUE_DEPTH);
    assign out_cmd.valid = count_reg != '0;
    assign out_cmd.cmd   = slot_mem[rd_ptr_reg];

    assign push = in_cmd.valid && in_ready;
    assign pop  = out_cmd.valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_mem[wr_ptr_reg] <= in_cmd.cmd;
        end
    end

endmodule

/* hdl/bbc_back.sv */
// Stack engine: execute commands on the kind stack and register the verdicts.
`timescale 1ns / 1ps

module bbc_back import bbc_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_stream_t cmd_in,
    output logic        cmd_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic           stack_mem [STACK_DEPTH];
    logic [DW-1:0]  depth_reg, depth_next;
    logic           failed_reg, failed_next;
    logic           overflow_reg, overflow_next;
    kind_t          top_reg, top_next;
    kind_t          below_reg;
    logic           m_valid_reg, m_valid_next;
    verdict_t       verdict_reg, verdict_next;
    logic           out_free, take, busy_line, push;
    logic [DW-1:0]  below_idx;
    logic [AW-1:0]  rd_addr, wr_addr;
    kind_t          push_kind;
    verdict_t       line_verdict;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (cmd_in.cmd != CMD_EOL) || out_free;
    assign take      = cmd_in.valid && cmd_ready;
    assign busy_line = failed_reg || overflow_reg;

    always_comb begin
        if (overflow_reg)                         line_verdict = VERDICT_OVERFLOW;
        else if (failed_reg || depth_reg != '0)   line_verdict = VERDICT_NO;
        else                                      line_verdict = VERDICT_YES;
    end

    always_comb begin
        depth_next    = depth_reg;
        failed_next   = failed_reg;
        overflow_next = overflow_reg;
        top_next      = top_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        verdict_next  = verdict_reg;
        push          = 1'b0;
        push_kind     = KIND_ROUND;
        if (take) begin
            unique case (cmd_in.cmd)
                CMD_EOL: begin
                    m_valid_next  = 1'b1;
                    verdict_next  = line_verdict;
                    depth_next    = '0;
                    failed_next   = 1'b0;
                    overflow_next = 1'b0;
                end
                CMD_OPEN_ROUND, CMD_OPEN_SQUARE: begin
                    push_kind = (cmd_in.cmd == CMD_OPEN_SQUARE) ? KIND_SQUARE : KIND_ROUND;
                    if (!busy_line) begin
                        if (depth_reg == DW'(STACK_DEPTH)) begin
                            overflow_next = 1'b1;
                        end else begin
                            push       = 1'b1;
                            top_next   = push_kind;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                end
                CMD_CLOSE_ROUND, CMD_CLOSE_SQUARE, CMD_CLOSE_OTHER: begin
                    if (!busy_line) begin
                        if (depth_reg == '0) begin
                            failed_next = 1'b1;
                        end else begin
                            // Pop: the entry below the top is already prefetched.
                            depth_next = depth_reg - 1'b1;
                            top_next   = below_reg;
                            if ((cmd_in.cmd == CMD_CLOSE_SQUARE && top_reg == KIND_ROUND) ||
                                (cmd_in.cmd == CMD_CLOSE_ROUND && top_reg == KIND_SQUARE)) begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    depth_next = depth_reg;
                end
            endcase
        end
    end

    // Prefetch the entry just below the next top; wraps harmlessly when shallow.
    assign below_idx = depth_next - DW'(2);
    assign rd_addr   = below_idx[AW-1:0];
    assign wr_addr   = depth_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[wr_addr] <= push_kind;
        end
        below_reg <= kind_t'(stack_mem[rd_addr]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            failed_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            depth_reg    <= depth_next;
            failed_reg   <= failed_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
        top_reg     <= top_next;
        verdict_reg <= verdict_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = verdict_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> depth_reg == DW'(STACK_DEPTH))
        else $error("overflow flagged on a stack that is not full");

    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && cmd_in.cmd == CMD_EOL |=> m_valid_reg && depth_reg == '0
                                          && !failed_reg && !overflow_reg)
        else $error("end of line did not post a verdict and clear the line");

    a_eol_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_in.valid && cmd_in.cmd == CMD_EOL && m_valid_reg && !m_ready |-> !take)
        else $error("end of line consumed while a verdict is still pending");
`endif

endmodule

/* hdl/bracket_balance_checker_unit.sv */
// Top level of the bracket balance checker: front stage, command queue, stack engine.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  s_op (1: end of line), s_ch (8-bit byte)
//  m_       out        m_valid / m_ready  m_verdict (0 balanced, 1 unbalanced, 2 overflow)
//
//  Sustains one input transaction per cycle unless a stalled m_ backs up the queue;
//  the stack engine takes every item, push or pop, back to back, keeps the top entry
//  in a register, and prefetches the entry below from the memory's registered read port.
//  Each verdict reaches m_ via the front register, a queue slot and the output register.
//  Reset (aresetn low, synchronous) empties the front stage, the queue and the
//  output register and clears depth and flags; the stack memory is not cleared.
//  A stalled m_ channel holds only end-of-line commands; characters ahead of one keep
//  draining from the queue, and s_ready drops once the queue and front stage fill.

module bracket_balance_checker_unit import bbc_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);

    cmd_stream_t front_cmd;
    cmd_stream_t queue_cmd;
    logic        queue_in_ready;
    logic        back_ready;

    // Classify each transaction and hold it in a register until the queue takes it.
    bbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_ch      (s_ch),
        .cmd_out   (front_cmd),
        .cmd_ready (queue_in_ready)
    );

    // Decouple the front from the engine so either side may stall alone.
    bbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (front_cmd),
        .in_ready  (queue_in_ready),
        .out_cmd   (queue_cmd),
        .out_ready (back_ready)
    );

    // Execute pushes, pops and end-of-line verdicts.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_in    (queue_cmd),
        .cmd_ready (back_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bracket balance checker: line stimulus, verdict scoreboard.
`timescale 1ns / 1ps

module testbench import bbc_pkg::*;;

    // Predict the verdict of each line and match it with the block's results.
    class verdict_scoreboard;
        kind_t       open_kinds[DEFAULT_STACK_DEPTH];
        logic [10:0] open_count;
        bit          line_failed;
        bit          line_overflowed;
        verdict_t    expected_verdicts[$];
        int unsigned mismatches;

        function void note_input(op_t op, logic [7:0] ch);
            kind_t top;
            if (op == OP_EOL) begin
                if (line_overflowed)
                    expected_verdicts.push_back(VERDICT_OVERFLOW);
                else if (line_failed || open_count != 0)
                    expected_verdicts.push_back(VERDICT_NO);
                else
                    expected_verdicts.push_back(VERDICT_YES);
                open_count      = '0;
                line_failed     = 1'b0;
                line_overflowed = 1'b0;
            end else if (line_failed || line_overflowed) begin
                // rest of the line is dropped
            end else if (ch == CHAR_OPEN_ROUND || ch == CHAR_OPEN_SQUARE) begin
                if (open_count >= DEFAULT_STACK_DEPTH) begin
                    line_overflowed = 1'b1;
                end else begin
                    open_kinds[open_count] = (ch == CHAR_OPEN_SQUARE) ? KIND_SQUARE : KIND_ROUND;
                    open_count++;
                end
            end else if (open_count == 0) begin
                line_failed = 1'b1;
            end else begin
                open_count--;
                top = open_kinds[open_count];
                if ((ch == CHAR_CLOSE_SQUARE && top == KIND_ROUND) ||
                    (ch == CHAR_CLOSE_ROUND && top == KIND_SQUARE))
                    line_failed = 1'b1;
            end
        endfunction

        function void check_verdict(logic [1:0] got);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                $error("m_verdict: no verdict expected, got %0d", got);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got !== want) begin
                    $error("m_verdict: expected %0d, got %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    // Minimum transactions per idling phase in the random part.
    localparam int PHASE_ITEMS = 215;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic       s_op      = 1'b0;
    logic [7:0] s_ch      = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_verdict;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int sent_items         = 0;

    logic [7:0]        line_buf[$];
    verdict_scoreboard sb;

    bracket_balance_checker_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_ch      (s_ch),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the verdict channel at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check every verdict transaction; values read here are those held before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_verdict(m_verdict);
    end

    function automatic logic [7:0] opener_of(kind_t k);
        return (k == KIND_SQUARE) ? CHAR_OPEN_SQUARE : CHAR_OPEN_ROUND;
    endfunction

    function automatic logic [7:0] closer_of(kind_t k);
        return (k == KIND_SQUARE) ? CHAR_CLOSE_SQUARE : CHAR_CLOSE_ROUND;
    endfunction

    function automatic logic [7:0] bracket_byte();
        case ($urandom_range(3))
            0: return CHAR_OPEN_ROUND;
            1: return CHAR_OPEN_SQUARE;
            2: return CHAR_CLOSE_ROUND;
            default: return CHAR_CLOSE_SQUARE;
        endcase
    endfunction

    // Any byte other than the four brackets: pops without a kind check.
    function automatic logic [7:0] other_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CHAR_OPEN_ROUND || c == CHAR_OPEN_SQUARE ||
               c == CHAR_CLOSE_ROUND || c == CHAR_CLOSE_SQUARE);
        return c;
    endfunction

    // Weight brackets heavily so that noise still exercises the stack.
    function automatic logic [7:0] any_byte();
        return $urandom_range(1) ? bracket_byte() : 8'($urandom_range(255));
    endfunction

    // Hold one transaction on s_ until it is taken, after a random idle gap.
    task automatic send_item(op_t op, logic [7:0] ch);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_ch    <= ch;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_input(op, ch);
        sent_items++;
    endtask

    // Send the buffered characters, then close the line with a random unused byte.
    task automatic send_line();
        foreach (line_buf[i])
            send_item(OP_CHAR, line_buf[i]);
        send_item(OP_EOL, 8'($urandom_range(255)));
    endtask

    // Lines that reach the bottom of the stack:
    //   0  fill to the last entry and drain in order, balanced
    //   1  one push past full, then closers that must be dropped
    //   2  fail on an empty stack first, then pushes past full (no overflow reported)
    //   3  fill and drain, with the very last closer of the wrong kind
    task automatic build_deep_line(int variant);
        kind_t opened[$];
        kind_t k;
        int    n_open;
        line_buf = {};
        if (variant == 2)
            line_buf.push_back(CHAR_CLOSE_ROUND);
        n_open = (variant == 1 || variant == 2) ? DEFAULT_STACK_DEPTH + 1 : DEFAULT_STACK_DEPTH;
        for (int i = 0; i < n_open; i++) begin
            k = kind_t'($urandom_range(1));
            opened.push_back(k);
            line_buf.push_back(opener_of(k));
        end
        if (variant == 1) begin
            line_buf.push_back(CHAR_CLOSE_ROUND);
            line_buf.push_back(CHAR_CLOSE_SQUARE);
            line_buf.push_back(other_byte());
        end else if (variant != 2) begin
            while (opened.size() != 0) begin
                k = opened.pop_back();
                if (variant == 3 && opened.size() == 0)
                    k = (k == KIND_ROUND) ? KIND_SQUARE : KIND_ROUND;
                line_buf.push_back(closer_of(k));
            end
        end
    endtask

    // Mostly well-formed lines with random content, some corrupted, the rest noise.
    task automatic build_random_line();
        kind_t opened[$];
        kind_t k;
        int    len;
        int    style;
        int    pos;
        line_buf = {};
        style = $urandom_range(99);
        if (style < 70) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
            for (int i = 0; i < len; i++) begin
                if (opened.size() != 0 && $urandom_range(1)) begin
                    k = opened.pop_back();
                    line_buf.push_back(($urandom_range(6) == 0) ? other_byte() : closer_of(k));
                end else begin
                    k = kind_t'($urandom_range(1));
                    opened.push_back(k);
                    line_buf.push_back(opener_of(k));
                end
            end
            while (opened.size() != 0)
                line_buf.push_back(closer_of(opened.pop_back()));
            // Break a quarter of them at one random spot.
            if ($urandom_range(3) == 0 && line_buf.size() != 0) begin
                pos = $urandom_range(line_buf.size() - 1);
                line_buf[pos] = any_byte();
            end
        end else begin
            len = $urandom_range(16);
            for (int i = 0; i < len; i++)
                line_buf.push_back((style < 85) ? any_byte() : bracket_byte());
        end
    endtask

    initial begin
        int phase_start;
        sb = new;

        // Hold reset low, then release it once.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines, no idling.
        line_buf = {};                                               // empty line
        send_line();
        line_buf = '{CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND};             // balanced
        send_line();
        line_buf = '{CHAR_OPEN_ROUND, CHAR_CLOSE_SQUARE};            // square meets round
        send_line();
        line_buf = '{CHAR_OPEN_SQUARE, CHAR_CLOSE_ROUND};            // round meets square
        send_line();
        line_buf = '{CHAR_CLOSE_SQUARE};                             // closer on empty stack
        send_line();
        line_buf = '{CHAR_OPEN_ROUND, 8'h00};                        // other byte pops round
        send_line();
        line_buf = '{CHAR_OPEN_SQUARE, 8'hFF};                       // other byte pops square
        send_line();
        line_buf = '{8'hFF};                                         // other byte, empty stack
        send_line();
        line_buf = '{CHAR_OPEN_SQUARE};                              // left open
        send_line();

        // Four idling phases; the last is led by one line that overflows the stack.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            if (phase == 3) begin
                build_deep_line(1);
                send_line();
            end
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                build_random_line();
                send_line();
            end
        end
        s_valid <= 1'b0;

        // Drain the remaining verdicts, then allow the pipeline to settle.
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Abort a hung run well past the slowest correct one.
    initial begin
        #400_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
